// ----- design/assert_macros.svh -----
// shared assertion forms for the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PS2D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition at one edge implies a consequence at the next edge
`define PS2D_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ----- design/ps2d_pkg.sv -----
package ps2d_pkg;

    // result kinds
    localparam logic [2:0] KIND_ECHO  = 3'd0;
    localparam logic [2:0] KIND_LED   = 3'd1;
    localparam logic [2:0] KIND_READ  = 3'd2;
    localparam logic [2:0] KIND_EMPTY = 3'd3;
    localparam logic [2:0] KIND_NONE  = 3'd4;

    // input actions
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // set 1 scan codes
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_CTRL       = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
    localparam logic [7:0] SC_ALT        = 8'h38;
    localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
    localparam logic [7:0] SC_CAPS       = 8'h3A;
    localparam logic [7:0] SC_NUM        = 8'h45;
    localparam logic [7:0] SC_SCROLL     = 8'h46;
    localparam logic [7:0] SC_CAPS_BRK   = 8'hBA;
    localparam logic [7:0] SC_NUM_BRK    = 8'hC5;
    localparam logic [7:0] SC_SCROLL_BRK = 8'hC6;
    localparam logic [7:0] SC_EXT        = 8'hE0;

    localparam logic [7:0] LED_CMD = 8'hED;

    // led mask bits
    localparam logic [2:0] LED_SCROLL = 3'b001;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_CAPS   = 3'b100;

    // result queue between front and back
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] locks;
        logic [2:0] mods;
        logic       pair;   // led command byte goes out ahead of data
    } t_res;

    // keymap: four pages picked by shift and caps
    function automatic logic [7:0] key_char(input logic shift, input logic caps,
                                            input logic [6:0] code);
        logic       upper;
        logic       sh_only;
        logic       letter;
        logic [7:0] c;
        upper   = shift ^ caps;
        sh_only = shift & ~caps;
        letter  = code inside {[7'h10:7'h19], [7'h1E:7'h26], [7'h2C:7'h32]};
        c       = 8'd0;
        case (code)
            7'h01: c = 8'd27;
            7'h0E: c = 8'd8;
            7'h0F: c = 8'd9;
            7'h1C: c = 8'd10;
            7'h37: c = "*";
            7'h39: c = " ";
            7'h02: c = shift ? "!"  : "1";
            7'h03: c = shift ? "\"" : "2";
            7'h04: c = shift ? 8'd0 : "3";
            7'h05: c = shift ? "$"  : "4";
            7'h06: c = shift ? "%"  : "5";
            7'h07: c = shift ? "&"  : "6";
            7'h08: c = shift ? "/"  : "7";
            7'h09: c = shift ? "("  : "8";
            7'h0A: c = shift ? ")"  : "9";
            7'h0B: c = shift ? "="  : "0";
            7'h0C: c = shift ? "?"  : "'";
            7'h0D: c = shift ? "^"  : 8'd0;
            7'h10: c = "q";
            7'h11: c = "w";
            7'h12: c = "e";
            7'h13: c = "r";
            7'h14: c = "t";
            7'h15: c = "y";
            7'h16: c = "u";
            7'h17: c = "i";
            7'h18: c = "o";
            7'h19: c = "p";
            7'h1E: c = "a";
            7'h1F: c = "s";
            7'h20: c = "d";
            7'h21: c = "f";
            7'h22: c = "g";
            7'h23: c = "h";
            7'h24: c = "j";
            7'h25: c = "k";
            7'h26: c = "l";
            7'h2C: c = "z";
            7'h2D: c = "x";
            7'h2E: c = "c";
            7'h2F: c = "v";
            7'h30: c = "b";
            7'h31: c = "n";
            7'h32: c = "m";
            7'h2B: c = upper ? "|" : "\\";
            7'h33: c = sh_only ? ";" : ",";
            7'h34: c = sh_only ? ":" : ".";
            7'h35: c = sh_only ? "_" : "-";
            7'h4A: c = sh_only ? 8'd0 : "-";
            7'h4E: c = sh_only ? 8'd0 : "+";
            7'h47: c = sh_only ? "7" : 8'd0;
            7'h48: c = sh_only ? "8" : 8'd0;
            7'h49: c = sh_only ? "9" : 8'd0;
            7'h4B: c = sh_only ? "4" : 8'd0;
            7'h4C: c = sh_only ? "5" : 8'd0;
            7'h4D: c = sh_only ? "6" : 8'd0;
            7'h4F: c = sh_only ? "1" : 8'd0;
            7'h50: c = sh_only ? "2" : 8'd0;
            7'h51: c = sh_only ? "3" : 8'd0;
            7'h52: c = sh_only ? "0" : 8'd0;
            default: c = 8'd0;
        endcase
        if (letter && upper) begin
            c = c - 8'd32;
        end
        return c;
    endfunction

endpackage

// ----- design/ps2d_front.sv -----
`include "assert_macros.svh"

module ps2d_front #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_data,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_action,
    input  logic [7:0]      i_code,
    output logic            o_push,
    input  logic            i_push_ready,
    output ps2d_pkg::t_res  o_res
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]      r_mem [QUEUE_DEPTH];
    logic [7:0]      r_rd;
    logic            r_echo;
    logic            r_shift, r_ctrl, r_alt, r_caps, r_released;
    logic [2:0]      r_led;
    logic [PW-1:0]   r_head, r_tail;
    logic [CW-1:0]   r_count;
    logic            r_s_valid;
    ps2d_pkg::t_res  r_s;

    logic            n_shift, n_ctrl, n_alt, n_caps, n_released;
    logic [2:0]      n_led;
    logic [2:0]      lock_bit;
    logic            push_ch, pop;
    logic            full, empty, accept;
    logic [7:0]      ch;
    ps2d_pkg::t_res  res;

    assign o_ready = !r_s_valid || i_push_ready;
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CW'(QUEUE_DEPTH));
    assign empty   = (r_count == '0);
    assign ch      = ps2d_pkg::key_char(r_shift, r_caps, i_code[6:0]);

    always_comb begin
        n_shift    = r_shift;
        n_ctrl     = r_ctrl;
        n_alt      = r_alt;
        n_caps     = r_caps;
        n_led      = r_led;
        n_released = r_released;
        lock_bit   = '0;
        push_ch    = 1'b0;
        pop        = 1'b0;
        res.kind   = ps2d_pkg::KIND_NONE;
        res.data   = 8'd0;
        res.pair   = 1'b0;
        if (i_action == ps2d_pkg::ACT_READ) begin
            if (empty) begin
                res.kind = ps2d_pkg::KIND_EMPTY;
            end else begin
                pop      = 1'b1;
                res.kind = ps2d_pkg::KIND_READ;
            end
        end else begin
            case (i_code)
                ps2d_pkg::SC_LSHIFT, ps2d_pkg::SC_RSHIFT: n_shift = 1'b1;
                ps2d_pkg::SC_LSHIFT_BRK, ps2d_pkg::SC_RSHIFT_BRK: n_shift = 1'b0;
                ps2d_pkg::SC_CTRL: n_ctrl = 1'b1;
                ps2d_pkg::SC_CTRL_BRK: n_ctrl = 1'b0;
                ps2d_pkg::SC_ALT: n_alt = 1'b1;
                ps2d_pkg::SC_ALT_BRK: n_alt = 1'b0;
                ps2d_pkg::SC_CAPS: lock_bit = ps2d_pkg::LED_CAPS;
                ps2d_pkg::SC_NUM: lock_bit = ps2d_pkg::LED_NUM;
                ps2d_pkg::SC_SCROLL: lock_bit = ps2d_pkg::LED_SCROLL;
                ps2d_pkg::SC_CAPS_BRK, ps2d_pkg::SC_NUM_BRK,
                ps2d_pkg::SC_SCROLL_BRK: n_released = 1'b1;
                ps2d_pkg::SC_EXT: ;
                default: begin
                    // make codes translate; dropped when the char queue is full
                    if (!i_code[7] && !full) begin
                        push_ch = 1'b1;
                        if (r_echo) begin
                            res.kind = ps2d_pkg::KIND_ECHO;
                            res.data = ch;
                        end
                    end
                end
            endcase
            if (lock_bit != '0 && r_released) begin
                n_led      = r_led ^ lock_bit;
                n_released = 1'b0;
                if (lock_bit == ps2d_pkg::LED_CAPS) begin
                    n_caps = ~r_caps;
                end
                res.kind = ps2d_pkg::KIND_LED;
                res.data = {5'd0, n_led};
                res.pair = 1'b1;
            end
        end
        res.locks = n_led;
        res.mods  = {n_alt, n_ctrl, n_shift};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo     <= 1'b1;
            r_shift    <= 1'b0;
            r_ctrl     <= 1'b0;
            r_alt      <= 1'b0;
            r_caps     <= 1'b0;
            r_led      <= '0;
            r_released <= 1'b1;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_s_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_echo <= i_cfg_data;
            end
            if (accept) begin
                r_shift    <= n_shift;
                r_ctrl     <= n_ctrl;
                r_alt      <= n_alt;
                r_caps     <= n_caps;
                r_led      <= n_led;
                r_released <= n_released;
                if (push_ch) begin
                    r_tail  <= (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    r_count <= r_count + 1'b1;
                end
                if (pop) begin
                    r_head  <= (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    r_count <= r_count - 1'b1;
                end
                r_s_valid <= 1'b1;
            end else if (i_push_ready) begin
                r_s_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s <= res;
        end
    end

    // char queue storage, one write or one registered read per accepted item, never both
    always_ff @(posedge i_clk) begin
        if (accept && push_ch) begin
            r_mem[r_tail] <= ch;
        end
        if (accept && pop) begin
            r_rd <= r_mem[r_head];
        end
    end

    always_comb begin
        o_res = r_s;
        if (r_s.kind == ps2d_pkg::KIND_READ) begin
            o_res.data = r_rd;
        end
    end

    assign o_push = r_s_valid;

    `PS2D_ASSERT(a_count_bound, r_count <= CW'(QUEUE_DEPTH), "char queue count overflow")
    `PS2D_ASSERT_NEXT(a_stage_hold, r_s_valid && !i_push_ready, r_s_valid && $stable(r_s),
        "front stage lost a stalled item")

endmodule

// ----- design/ps2d_rq.sv -----
`include "assert_macros.svh"

module ps2d_rq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ps2d_pkg::t_res  i_res,
    output logic            o_valid,
    input  logic            i_ready,
    output ps2d_pkg::t_res  o_res
);

    localparam int AW = ps2d_pkg::RQ_AW;

    ps2d_pkg::t_res  r_buf [ps2d_pkg::RQ_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_count;
    logic            wr, rd;

    assign o_ready = (r_count != (AW + 1)'(ps2d_pkg::RQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;
    assign o_res   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_buf[r_wp] <= i_res;
        end
    end

    `PS2D_ASSERT(a_rq_bound, r_count <= (AW + 1)'(ps2d_pkg::RQ_DEPTH),
        "result queue count overflow")

endmodule

// ----- design/ps2d_back.sv -----
`include "assert_macros.svh"

module ps2d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ps2d_pkg::t_res  i_res,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_data,
    output logic [2:0]      o_locks,
    output logic [2:0]      o_mods,
    output logic            o_last
);

    logic        r_valid;
    logic        r_phase;   // command byte of a pair already loaded into the output register
    logic [2:0]  r_kind;
    logic [7:0]  r_data;
    logic [2:0]  r_locks;
    logic [2:0]  r_mods;
    logic        r_last;
    logic        load;
    logic        first_of_pair;

    assign load          = !r_valid || i_ready;
    assign first_of_pair = i_res.pair && !r_phase;
    assign o_ready       = load && !first_of_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_phase <= first_of_pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_kind  <= i_res.kind;
            r_locks <= i_res.locks;
            r_mods  <= i_res.mods;
            r_data  <= first_of_pair ? ps2d_pkg::LED_CMD : i_res.data;
            r_last  <= !first_of_pair;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_data  = r_data;
    assign o_locks = r_locks;
    assign o_mods  = r_mods;
    assign o_last  = r_last;

    `PS2D_ASSERT(a_phase_held, !r_phase || i_valid, "pair entry left the queue too early")
    `PS2D_ASSERT_NEXT(a_pair_order,
        r_valid && i_ready && !r_last,
        r_valid && r_last && r_kind == ps2d_pkg::KIND_LED,
        "led command byte not followed by its mask")

endmodule

// ----- design/ps2_scancode_to_ascii_decoder.sv -----
// path: each result passes the front stage register, the result queue and the output register
// throughput: one item per cycle while the output is not stalled; a lock toggle gives two results
// the 4-entry result queue absorbs that and lets the front run on until it fills
// reset: sync active low, clears modifiers, locks, char queue pointers, echo on
// the char queue storage is not cleared; entries are read only after being written
module ps2_scancode_to_ascii_decoder #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,       // echo_enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] scan_code
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [10:8] lock_status,
                                        // [13:11] modifier_status, [15:14] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast
);

    logic            fr_push, fr_ready;
    ps2d_pkg::t_res  fr_res;
    logic            rq_valid, rq_ready;
    ps2d_pkg::t_res  rq_res;
    logic [7:0]      bk_data;
    logic [2:0]      bk_locks, bk_mods;

    assign cfg_ready = 1'b1;

    ps2d_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_data   (cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_code       (s_axis_tdata),
        .o_push       (fr_push),
        .i_push_ready (fr_ready),
        .o_res        (fr_res)
    );

    ps2d_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_push),
        .o_ready (fr_ready),
        .i_res   (fr_res),
        .o_valid (rq_valid),
        .i_ready (rq_ready),
        .o_res   (rq_res)
    );

    ps2d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rq_valid),
        .o_ready (rq_ready),
        .i_res   (rq_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_data  (bk_data),
        .o_locks (bk_locks),
        .o_mods  (bk_mods),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, bk_mods, bk_locks, bk_data};

endmodule

// ----- tb/tb_ps2_scancode_to_ascii_decoder.sv -----
`timescale 1ns / 1ps

module tb_ps2_scancode_to_ascii_decoder;

    localparam int QDEPTH      = 256;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] locks;
        logic [2:0] mods;
        logic       last;
    } t_dec_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] scan_code
    logic        s_axis_tuser = 1'b0;    // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] data_byte, [10:8] lock_status,
                                         // [13:11] modifier_status, [15:14] zero
    logic [2:0]  m_axis_tuser;           // [2:0] kind
    logic        m_axis_tlast;

    ps2_scancode_to_ascii_decoder #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // keyboard state as the decoder should hold it
    logic       echo_on    = 1'b1;
    logic       shift_held = 1'b0;
    logic       ctrl_held  = 1'b0;
    logic       alt_held   = 1'b0;
    logic       caps_on    = 1'b0;
    logic [2:0] led_mask   = 3'b000;
    logic       lock_free  = 1'b1;
    logic [7:0] char_store [QDEPTH];
    int         q_count = 0;
    int         q_head  = 0;
    int         q_tail  = 0;
    logic [7:0] keymap [512];

    t_dec_result pending_results [$];
    int          errors = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    // four pages of 128: plain, shift, caps, caps with shift
    initial begin
        string digits, shpunct, top, mid, bot, kpad;
        logic  upper, shifted;
        digits  = "1234567890'";
        shpunct = "!\"#$%&/()=?^";
        top     = "qwertyuiop";
        mid     = "asdfghjkl";
        bot     = "zxcvbnm";
        kpad    = "789-456+1230";
        foreach (keymap[i]) keymap[i] = 8'd0;
        for (int p = 0; p < 512; p += 128) begin
            shifted = (p == 128) || (p == 384);
            upper   = (p == 128) || (p == 256);
            keymap[p + 8'h01] = 8'd27;
            keymap[p + 8'h0E] = 8'd8;
            keymap[p + 8'h0F] = 8'd9;
            keymap[p + 8'h1C] = 8'd10;
            keymap[p + 8'h37] = "*";
            keymap[p + 8'h39] = " ";
            for (int i = 0; i < top.len(); i++)
                keymap[p + 8'h10 + i] = upper ? top[i] - 8'd32 : top[i];
            for (int i = 0; i < mid.len(); i++)
                keymap[p + 8'h1E + i] = upper ? mid[i] - 8'd32 : mid[i];
            for (int i = 0; i < bot.len(); i++)
                keymap[p + 8'h2C + i] = upper ? bot[i] - 8'd32 : bot[i];
            if (shifted) begin
                for (int i = 0; i < shpunct.len(); i++) keymap[p + 8'h02 + i] = shpunct[i];
                keymap[p + 8'h04] = 8'd0;
            end else begin
                for (int i = 0; i < digits.len(); i++) keymap[p + 8'h02 + i] = digits[i];
            end
            keymap[p + 8'h2B] = upper ? "|" : "\\";
            if (p == 128) begin
                keymap[p + 8'h33] = ";";
                keymap[p + 8'h34] = ":";
                keymap[p + 8'h35] = "_";
                // keypad digits only on the shift page, no keypad ops there
                for (int i = 0; i < kpad.len(); i++) keymap[p + 8'h47 + i] = kpad[i];
                keymap[p + 8'h4A] = 8'd0;
                keymap[p + 8'h4E] = 8'd0;
            end else begin
                keymap[p + 8'h33] = ",";
                keymap[p + 8'h34] = ".";
                keymap[p + 8'h35] = "-";
                keymap[p + 8'h4A] = "-";
                keymap[p + 8'h4E] = "+";
            end
        end
    end

    function automatic void push_result(input logic [2:0] kind, input logic [7:0] data,
                                        input logic last);
        t_dec_result r;
        r.kind  = kind;
        r.data  = data;
        r.locks = led_mask;
        r.mods  = {alt_held, ctrl_held, shift_held};
        r.last  = last;
        pending_results.push_back(r);
    endfunction

    function automatic void decode_item(input logic act, input logic [7:0] code);
        logic [2:0] lock_bit;
        logic [7:0] ch;
        logic       echo_it;
        lock_bit = 3'b000;
        ch       = 8'd0;
        echo_it  = 1'b0;
        if (act == ps2d_pkg::ACT_READ) begin
            if (q_count == 0) begin
                push_result(ps2d_pkg::KIND_EMPTY, 8'd0, 1'b1);
            end else begin
                ch      = char_store[q_head];
                q_head  = (q_head + 1) % QDEPTH;
                q_count = q_count - 1;
                push_result(ps2d_pkg::KIND_READ, ch, 1'b1);
            end
            return;
        end
        case (code)
            ps2d_pkg::SC_LSHIFT, ps2d_pkg::SC_RSHIFT:         shift_held = 1'b1;
            ps2d_pkg::SC_LSHIFT_BRK, ps2d_pkg::SC_RSHIFT_BRK: shift_held = 1'b0;
            ps2d_pkg::SC_CTRL:                                ctrl_held = 1'b1;
            ps2d_pkg::SC_CTRL_BRK:                            ctrl_held = 1'b0;
            ps2d_pkg::SC_ALT:                                 alt_held = 1'b1;
            ps2d_pkg::SC_ALT_BRK:                             alt_held = 1'b0;
            ps2d_pkg::SC_CAPS:                                lock_bit = ps2d_pkg::LED_CAPS;
            ps2d_pkg::SC_NUM:                                 lock_bit = ps2d_pkg::LED_NUM;
            ps2d_pkg::SC_SCROLL:                              lock_bit = ps2d_pkg::LED_SCROLL;
            ps2d_pkg::SC_CAPS_BRK, ps2d_pkg::SC_NUM_BRK,
            ps2d_pkg::SC_SCROLL_BRK:                          lock_free = 1'b1;
            ps2d_pkg::SC_EXT: ;
            default: begin
                // full queue drops the key silently
                if (code < 8'h80 && q_count < QDEPTH) begin
                    ch = keymap[{caps_on, shift_held, code[6:0]}];
                    char_store[q_tail] = ch;
                    q_tail  = (q_tail + 1) % QDEPTH;
                    q_count = q_count + 1;
                    echo_it = echo_on;
                end
            end
        endcase
        if (lock_bit != 3'b000 && lock_free) begin
            led_mask = led_mask ^ lock_bit;
            if (lock_bit == ps2d_pkg::LED_CAPS) caps_on = ~caps_on;
            lock_free = 1'b0;
            push_result(ps2d_pkg::KIND_LED, ps2d_pkg::LED_CMD, 1'b0);
            push_result(ps2d_pkg::KIND_LED, {5'd0, led_mask}, 1'b1);
        end else if (echo_it) begin
            push_result(ps2d_pkg::KIND_ECHO, ch, 1'b1);
        end else begin
            push_result(ps2d_pkg::KIND_NONE, 8'd0, 1'b1);
        end
    endfunction

    function automatic void report_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void check_result();
        t_dec_result want;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected nothing, actual kind %0d data %02h",
                     $time, m_axis_tuser, m_axis_tdata[7:0]);
            return;
        end
        want = pending_results.pop_front();
        report_field("kind", want.kind, m_axis_tuser);
        report_field("data_byte", want.data, m_axis_tdata[7:0]);
        report_field("lock_status", want.locks, m_axis_tdata[10:8]);
        report_field("modifier_status", want.mods, m_axis_tdata[13:11]);
        report_field("last", want.last, m_axis_tlast);
    endfunction

    // result side: checks each item taken, stalls at random or for a long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_result();
            if (hold_req != hold_seen) begin
                hold_seen     <= hold_req;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // valid stays high between back-to-back items, dropped for a random gap or by wait_idle
    task automatic send_item(input logic act, input logic [7:0] code);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_item(act, code);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_echo(input logic en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        echo_on = en;
    endtask

    task automatic send_key();
        send_item(ps2d_pkg::ACT_SCAN, 8'($urandom_range(8'h7F)));
    endtask

    task automatic send_lock(input logic brk);
        logic [7:0] code;
        case ($urandom_range(2))
            0:       code = brk ? ps2d_pkg::SC_CAPS_BRK : ps2d_pkg::SC_CAPS;
            1:       code = brk ? ps2d_pkg::SC_NUM_BRK : ps2d_pkg::SC_NUM;
            default: code = brk ? ps2d_pkg::SC_SCROLL_BRK : ps2d_pkg::SC_SCROLL;
        endcase
        send_item(ps2d_pkg::ACT_SCAN, code);
    endtask

    task automatic test_directed();
        send_item(ps2d_pkg::ACT_READ, 8'h00);         // read with nothing queued
        send_item(ps2d_pkg::ACT_READ, 8'hFF);
        send_item(ps2d_pkg::ACT_SCAN, 8'h00);         // unmapped key queues a zero
        send_item(ps2d_pkg::ACT_SCAN, 8'h7F);
        send_item(ps2d_pkg::ACT_SCAN, 8'hFF);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_EXT);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_LSHIFT);
        send_item(ps2d_pkg::ACT_SCAN, 8'h1E);
        send_item(ps2d_pkg::ACT_SCAN, 8'h02);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_LSHIFT_BRK);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_RSHIFT);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_RSHIFT_BRK);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_CTRL);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_ALT);
        send_item(ps2d_pkg::ACT_SCAN, 8'h0E);         // backspace is just a character
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_ALT_BRK);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_CTRL_BRK);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_CAPS);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_CAPS);       // still held, no toggle
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_NUM);        // shared guard blocks this too
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_CAPS_BRK);
        send_item(ps2d_pkg::ACT_SCAN, 8'h1E);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_NUM);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_NUM_BRK);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_SCROLL);
        send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_SCROLL_BRK);
        wait_idle();
    endtask

    task automatic test_echo_off();
        write_echo(1'b0);
        repeat (4) send_key();
        repeat (3) send_item(ps2d_pkg::ACT_READ, 8'($urandom));
        wait_idle();
        write_echo(1'b1);
    endtask

    task automatic test_queue_full();
        write_echo(1'b0);
        while (q_count < QDEPTH) send_key();
        repeat (3) send_key();              // dropped
        wait_idle();
        write_echo(1'b1);
        repeat (2) send_key();              // dropped, nothing echoed
        while (q_count > 0) send_item(ps2d_pkg::ACT_READ, 8'($urandom));
        send_item(ps2d_pkg::ACT_READ, 8'($urandom));
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_req <= hold_req + 1;
        repeat (40) begin
            if ($urandom_range(3) == 0) send_item(ps2d_pkg::ACT_READ, 8'($urandom));
            else send_key();
        end
        wait_idle();
    endtask

    task automatic test_random_phase(input int gap_pct, input int stall_pct, input logic en);
        int start;
        write_echo(en);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < 15) begin
            case ($urandom_range(99)) inside
                [0:29]:  send_key();
                [30:54]: send_item(ps2d_pkg::ACT_READ, 8'($urandom));
                [55:64]: begin
                    send_item(ps2d_pkg::ACT_SCAN,
                              $urandom_range(1) ? ps2d_pkg::SC_LSHIFT : ps2d_pkg::SC_RSHIFT);
                    repeat ($urandom_range(1, 3)) send_key();
                    send_item(ps2d_pkg::ACT_SCAN, $urandom_range(1) ?
                              ps2d_pkg::SC_LSHIFT_BRK : ps2d_pkg::SC_RSHIFT_BRK);
                end
                [65:74]: begin
                    send_lock(1'b0);
                    if ($urandom_range(2) == 0) send_lock(1'b0);
                    send_key();
                    send_lock(1'b1);
                end
                [75:79]: begin
                    send_item(ps2d_pkg::ACT_SCAN,
                              $urandom_range(1) ? ps2d_pkg::SC_CTRL : ps2d_pkg::SC_ALT);
                    send_key();
                    send_item(ps2d_pkg::ACT_SCAN,
                              $urandom_range(1) ? ps2d_pkg::SC_CTRL_BRK : ps2d_pkg::SC_ALT_BRK);
                end
                [80:86]: begin
                    send_item(ps2d_pkg::ACT_SCAN, ps2d_pkg::SC_EXT);
                    send_item(ps2d_pkg::ACT_SCAN, 8'($urandom));
                end
                default: send_item(1'($urandom), 8'($urandom));
            endcase
        end
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_echo_off();
        test_queue_full();
        test_backpressure();
        test_random_phase(0, 0, 1'b1);
        test_random_phase(87, 0, 1'b0);
        test_random_phase(0, 87, 1'b1);
        test_random_phase(24, 24, 1'b1);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
